// ----- hdl/vertex_projection_onto_line_defines.svh -----
// Assertion macros for the vertex projection block.
`ifndef VERTEX_PROJECTION_ONTO_LINE_DEFINES_SVH
`define VERTEX_PROJECTION_ONTO_LINE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VPOL_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define VPOL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/vpol_pkg.sv -----
// Shared types, codes and defaults of the vertex projection block.
`default_nettype none
package vpol_pkg;

   localparam int VERTEX_COUNT_DEF = 8192;
   localparam int FRAC_SHIFT_DEF   = 16;
   localparam int MAC_STEPS        = 33;
   localparam int DIV_STEPS        = 64;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_PROJ  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [12:0]        vertex_index;
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic [12:0]        line_start_index;
      logic [12:0]        line_end_index;
      logic signed [31:0] line_dx;
      logic signed [31:0] line_dy;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               moved;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic clear;
   } mac_cmd_type;

endpackage
`default_nettype wire

// ----- hdl/vertex_projection_onto_line.sv -----
// Top level: vertex tables, mark table, command sequencer and result register.
// Project: nine bit-serial 33-step multiply-adds, then 64-step divides for x and y; the
// first divide overlaps the last three multiply-adds. One item is in work at a time;
// the next is taken while a result waits. After reset every mark table entry is swept
// to zero; no item is taken then.
`default_nettype none
`include "vertex_projection_onto_line_defines.svh"
module vertex_projection_onto_line #(
   parameter int VERTEX_COUNT = vpol_pkg::VERTEX_COUNT_DEF,
   parameter int FRAC_SHIFT   = vpol_pkg::FRAC_SHIFT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire vpol_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vpol_pkg::rsp_type      rsp_data
);

   localparam int AW = $clog2(VERTEX_COUNT);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_RDW  = 4'd3;
   localparam logic [3:0] S_P2   = 4'd4;
   localparam logic [3:0] S_MAC  = 4'd5;
   localparam logic [3:0] S_DIV2 = 4'd6;
   localparam logic [3:0] S_EMIT = 4'd7;

   localparam logic [3:0] OP_AA  = 4'd0;
   localparam logic [3:0] OP_BB  = 4'd1;
   localparam logic [3:0] OP_AB  = 4'd2;
   localparam logic [3:0] OP_NX0 = 4'd3;
   localparam logic [3:0] OP_NX1 = 4'd4;
   localparam logic [3:0] OP_NX2 = 4'd5;
   localparam logic [3:0] OP_NY0 = 4'd6;
   localparam logic [3:0] OP_NY1 = 4'd7;
   localparam logic [3:0] OP_NY2 = 4'd8;

   logic [31:0] x_mem [VERTEX_COUNT];
   logic [31:0] y_mem [VERTEX_COUNT];
   logic        mark_mem [VERTEX_COUNT];

   logic [3:0]        state_ff, state_in;
   vpol_pkg::req_type req_ff, req_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic              clr_cmd_ff, clr_cmd_in;
   logic [31:0]       x0_ff, x0_in, y0_ff, y0_in;
   logic [31:0]       x1_ff, x1_in, y1_ff, y1_in;
   logic [63:0]       a2_ff, a2_in, b2_ff, b2_in, ab_ff, ab_in, s_ff, s_in;
   logic [3:0]        op_ff, op_in;
   logic [31:0]       qx_ff, qx_in;
   vpol_pkg::rsp_type res_ff, res_in;
   vpol_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rd_x_ff, rd_y_ff;
   logic              rd_mark_ff;

   logic              xy_we;
   logic [AW-1:0]     xy_wa;
   logic [31:0]       xy_wx, xy_wy;
   logic              mark_we;
   logic [AW-1:0]     mark_wa;
   logic              mark_wd;
   logic [AW-1:0]     rd_addr;

   logic [16:0]       in_w, idx_w, ls_w;
   logic              in_ok, idx_ok, ls_ok, proj_go, rsp_free;
   logic [AW-1:0]     idx_addr;
   logic signed [31:0] a_s, b_s;
   logic [3:0]        nop;

   vpol_pkg::mac_cmd_type mac_cmd;
   logic              mac_start, mac_clear;
   logic [63:0]       mac_mcand;
   logic [32:0]       mac_mplier;
   logic              mac_busy, mac_done;
   logic [63:0]       mac_acc;
   logic              div_start, div_busy, div_done;
   logic [31:0]       div_quo;

   assign mac_cmd = {mac_start, mac_clear};

   vpol_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mac_cmd),
      .mcand  (mac_mcand),
      .mplier (mac_mplier),
      .busy   (mac_busy),
      .done   (mac_done),
      .acc    (mac_acc)
   );

   vpol_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mac_acc),
      .den   (s_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      in_w     = 17'(req_data.vertex_index);
      idx_w    = 17'(req_ff.vertex_index);
      ls_w     = 17'(req_ff.line_start_index);
      in_ok    = (in_w < 17'(VERTEX_COUNT));
      idx_ok   = (idx_w < 17'(VERTEX_COUNT));
      ls_ok    = (ls_w < 17'(VERTEX_COUNT));
      idx_addr = idx_w[AW-1:0];
      a_s      = req_ff.line_dx >>> FRAC_SHIFT;
      b_s      = req_ff.line_dy >>> FRAC_SHIFT;
      proj_go  = idx_ok && ls_ok && (req_ff.line_dx != '0) && (req_ff.line_dy != '0);
      rsp_free = !rsp_valid_ff || !rsp_stall;
      rd_addr  = (state_ff == S_RDW) ? ls_w[AW-1:0] : idx_addr;
      nop      = (state_ff == S_P2) ? OP_AA : (op_ff + 4'd1);
   end

   always_comb begin
      mac_clear  = 1'b0;
      mac_mcand  = '0;
      mac_mplier = '0;
      case (nop)
         OP_AA: begin
            mac_clear  = 1'b1;
            mac_mcand  = 64'(a_s);
            mac_mplier = 33'(a_s);
         end
         OP_BB: begin
            mac_clear  = 1'b1;
            mac_mcand  = 64'(b_s);
            mac_mplier = 33'(b_s);
         end
         OP_AB: begin
            mac_clear  = 1'b1;
            mac_mcand  = 64'(a_s);
            mac_mplier = 33'(b_s);
         end
         OP_NX0: begin
            mac_clear  = 1'b1;
            mac_mcand  = a2_ff;
            mac_mplier = {x0_ff[31], x0_ff};
         end
         OP_NX1: begin
            mac_mcand  = b2_ff;
            mac_mplier = {x1_ff[31], x1_ff};
         end
         OP_NX2: begin
            mac_mcand  = ab_ff;
            mac_mplier = {y0_ff[31], y0_ff} - {y1_ff[31], y1_ff};
         end
         OP_NY0: begin
            mac_clear  = 1'b1;
            mac_mcand  = b2_ff;
            mac_mplier = {y0_ff[31], y0_ff};
         end
         OP_NY1: begin
            mac_mcand  = a2_ff;
            mac_mplier = {y1_ff[31], y1_ff};
         end
         OP_NY2: begin
            mac_mcand  = ab_ff;
            mac_mplier = {x0_ff[31], x0_ff} - {x1_ff[31], x1_ff};
         end
         default: begin
            mac_mcand  = '0;
            mac_mplier = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      clr_addr_in   = clr_addr_ff;
      clr_cmd_in    = clr_cmd_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      x1_in         = x1_ff;
      y1_in         = y1_ff;
      a2_in         = a2_ff;
      b2_in         = b2_ff;
      ab_in         = ab_ff;
      s_in          = s_ff;
      op_in         = op_ff;
      qx_in         = qx_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      xy_we         = 1'b0;
      xy_wa         = idx_addr;
      xy_wx         = div_quo;
      xy_wy         = div_quo;
      mark_we       = 1'b0;
      mark_wa       = idx_addr;
      mark_wd       = 1'b1;
      mac_start     = 1'b0;
      div_start     = 1'b0;
      req_stall     = (state_ff != S_IDLE);

      if (div_done && (state_ff == S_MAC)) begin
         qx_in = div_quo;
      end

      case (state_ff)
         S_CLR: begin
            mark_we     = 1'b1;
            mark_wa     = clr_addr_ff;
            mark_wd     = 1'b0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(VERTEX_COUNT - 1)) begin
               clr_addr_in = '0;
               clr_cmd_in  = 1'b0;
               if (!clr_cmd_ff) begin
                  state_in = S_IDLE;
               end else if (idx_ok) begin
                  state_in = S_RD;
               end else begin
                  res_in   = '0;
                  state_in = S_EMIT;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               case (req_data.cmd)
                  vpol_pkg::CMD_LOAD: begin
                     xy_we  = in_ok;
                     xy_wa  = in_w[AW-1:0];
                     xy_wx  = req_data.vertex_x;
                     xy_wy  = req_data.vertex_y;
                     res_in = '0;
                     if (in_ok) begin
                        res_in.out_x = req_data.vertex_x;
                        res_in.out_y = req_data.vertex_y;
                     end
                     state_in = S_EMIT;
                  end
                  vpol_pkg::CMD_CLEAR: begin
                     clr_cmd_in  = 1'b1;
                     clr_addr_in = '0;
                     state_in    = S_CLR;
                  end
                  default: begin
                     res_in   = '0;
                     state_in = in_ok ? S_RD : S_EMIT;
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_RDW;
         end
         S_RDW: begin
            x0_in        = rd_x_ff;
            y0_in        = rd_y_ff;
            res_in.out_x = rd_x_ff;
            res_in.out_y = rd_y_ff;
            res_in.moved = 1'b0;
            state_in     = S_EMIT;
            if ((req_ff.cmd == vpol_pkg::CMD_PROJ) && proj_go && !rd_mark_ff) begin
               mark_we = 1'b1;
               if ((req_ff.vertex_index != req_ff.line_start_index) &&
                   (req_ff.vertex_index != req_ff.line_end_index)) begin
                  state_in = S_P2;
               end
            end
         end
         S_P2: begin
            x1_in     = rd_x_ff;
            y1_in     = rd_y_ff;
            op_in     = OP_AA;
            mac_start = 1'b1;
            state_in  = S_MAC;
         end
         S_MAC: begin
            if (mac_done) begin
               op_in     = nop;
               mac_start = 1'b1;
               case (op_ff)
                  OP_AA: begin
                     a2_in = mac_acc;
                  end
                  OP_BB: begin
                     b2_in = mac_acc;
                     s_in  = a2_ff + mac_acc;
                  end
                  OP_AB: begin
                     ab_in = mac_acc;
                     if (s_ff == '0) begin
                        mac_start = 1'b0;
                        state_in  = S_EMIT;
                     end
                  end
                  OP_NX2: begin
                     div_start = 1'b1;
                  end
                  OP_NY2: begin
                     mac_start = 1'b0;
                     div_start = 1'b1;
                     state_in  = S_DIV2;
                  end
                  default: begin
                     op_in = nop;
                  end
               endcase
            end
         end
         S_DIV2: begin
            if (div_done) begin
               xy_we        = 1'b1;
               xy_wx        = qx_ff;
               xy_wy        = div_quo;
               res_in.out_x = qx_ff;
               res_in.out_y = div_quo;
               res_in.moved = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (xy_we) begin
         x_mem[xy_wa] <= xy_wx;
         y_mem[xy_wa] <= xy_wy;
      end
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      rd_mark_ff <= mark_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      x0_ff  <= x0_in;
      y0_ff  <= y0_in;
      x1_ff  <= x1_in;
      y1_ff  <= y1_in;
      a2_ff  <= a2_in;
      b2_ff  <= b2_in;
      ab_ff  <= ab_in;
      s_ff   <= s_in;
      op_ff  <= op_in;
      qx_ff  <= qx_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= S_CLR;
         clr_addr_ff  <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `VPOL_ASSERT_NEXT(a_accept_leaves_idle, req_valid && !req_stall, state_ff != S_IDLE)
   `VPOL_ASSERT_IMPLY(a_mac_start_idle, mac_start, !mac_busy)
   `VPOL_ASSERT_IMPLY(a_div_start_idle, div_start, !div_busy)
   `VPOL_ASSERT_NEXT(a_emit_shows, (state_ff == S_EMIT) && rsp_free, rsp_valid_ff)

endmodule
`default_nettype wire

// ----- hdl/vpol_mac.sv -----
// Bit-serial 64-bit multiply-accumulate unit with a signed 33-bit multiplier.
`default_nettype none
module vpol_mac (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire vpol_pkg::mac_cmd_type cmd,
   input  wire logic [63:0]           mcand,
   input  wire logic [32:0]           mplier,
   output logic                       busy,
   output logic                       done,
   output logic [63:0]                acc
);

   logic [63:0] mcand_ff, mcand_in;
   logic [32:0] mplier_ff, mplier_in;
   logic [63:0] acc_ff, acc_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        last;
   logic [63:0] term;

   always_comb begin
      last      = (count_ff == 6'(vpol_pkg::MAC_STEPS - 1));
      term      = mplier_ff[0] ? (last ? ~mcand_ff : mcand_ff) : '0;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         count_in  = '0;
         busy_in   = 1'b1;
         if (cmd.clear) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         acc_in    = acc_ff + term + 64'(mplier_ff[0] & last);
         mcand_in  = {mcand_ff[62:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[32:1]};
         count_in  = count_ff + 6'd1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      count_ff  <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign acc  = acc_ff;

endmodule
`default_nettype wire

// ----- hdl/vpol_div.sv -----
// Radix-2 restoring divider, signed 64-bit numerator by unsigned divisor.
`default_nettype none
module vpol_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [63:0] den,
   output logic             busy,
   output logic             done,
   output logic [31:0]      quo
);

   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic [64:0] diff;
   logic        ge;

   always_comb begin
      trial    = {rem_ff, quo_ff[63]};
      diff     = trial - {1'b0, den_ff};
      ge       = ~diff[64];
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = num[63] ? (64'd0 - num) : num;
         den_in   = den;
         neg_in   = num[63];
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[63:0] : trial[63:0];
         quo_in   = {quo_ff[62:0], ge};
         count_in = count_ff + 6'd1;
         if (count_ff == 6'(vpol_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = neg_ff ? (32'd0 - quo_ff[31:0]) : quo_ff[31:0];

endmodule
`default_nettype wire

// ----- tb/vertex_projection_onto_line_test.sv -----
// Testbench for the vertex projection block: directed and random items against a local model.
`timescale 1ns / 100ps
`default_nettype none
module vertex_projection_onto_line_test;

   localparam int NVERT = vpol_pkg::VERTEX_COUNT_DEF;
   localparam int WATCH_LIMIT = 40000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   vpol_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   vpol_pkg::rsp_type rsp_data;

   logic [31:0]       vx_tab [NVERT];
   logic [31:0]       vy_tab [NVERT];
   bit                mark_tab [NVERT];
   bit                loaded [NVERT];
   vpol_pkg::rsp_type expected_q [$];
   int                errors = 0;
   int                idle_cycles = 0;
   int                rsp_wait = 0;
   int                loaded_list [$];

   vertex_projection_onto_line dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [31:0] div_toward_zero(logic [63:0] num, logic [63:0] s);
      logic [63:0] mag;
      logic [63:0] q;
      mag = num[63] ? -num : num;
      q = mag / s;
      if (num[63]) q = -q;
      return q[31:0];
   endfunction

   function automatic vpol_pkg::rsp_type project_vertex(vpol_pkg::req_type r);
      vpol_pkg::rsp_type res;
      logic signed [63:0] a, b, x0, y0, x1, y1;
      logic [63:0] a2, b2, ab, s, nx, ny;
      bit ok;
      res = '0;
      ok = r.vertex_index < NVERT;
      case (r.cmd)
         vpol_pkg::CMD_LOAD: begin
            vx_tab[r.vertex_index] = r.vertex_x;
            vy_tab[r.vertex_index] = r.vertex_y;
         end
         vpol_pkg::CMD_PROJ: begin
            if (ok && r.line_start_index < NVERT && r.line_dx != 0 && r.line_dy != 0
                && !mark_tab[r.vertex_index]) begin
               mark_tab[r.vertex_index] = 1'b1;
               if (r.vertex_index != r.line_start_index
                   && r.vertex_index != r.line_end_index) begin
                  a = 64'(r.line_dx >>> 16);
                  b = 64'(r.line_dy >>> 16);
                  a2 = a * a; b2 = b * b; ab = a * b; s = a2 + b2;
                  if (s != 0) begin
                     x0 = 64'($signed(vx_tab[r.vertex_index]));
                     y0 = 64'($signed(vy_tab[r.vertex_index]));
                     x1 = 64'($signed(vx_tab[r.line_start_index]));
                     y1 = 64'($signed(vy_tab[r.line_start_index]));
                     nx = a2 * x0 + b2 * x1 + ab * (y0 - y1);
                     ny = b2 * y0 + a2 * y1 + ab * (x0 - x1);
                     vx_tab[r.vertex_index] = div_toward_zero(nx, s);
                     vy_tab[r.vertex_index] = div_toward_zero(ny, s);
                     res.moved = 1'b1;
                  end
               end
            end
         end
         vpol_pkg::CMD_CLEAR: begin
            foreach (mark_tab[i]) mark_tab[i] = 1'b0;
         end
         default: ;
      endcase
      res.out_x = vx_tab[r.vertex_index];
      res.out_y = vy_tab[r.vertex_index];
      return res;
   endfunction

   task automatic send_item(vpol_pkg::req_type r);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (r.cmd == vpol_pkg::CMD_LOAD) begin
         if (!loaded[r.vertex_index]) loaded_list.push_back(int'(r.vertex_index));
         loaded[r.vertex_index] = 1'b1;
      end
      expected_q.push_back(project_vertex(r));
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   function automatic vpol_pkg::req_type random_item(logic [1:0] cmd);
      vpol_pkg::req_type r;
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(vpol_pkg::req_type)-1:0];
      r.cmd = cmd;
      if (cmd != vpol_pkg::CMD_LOAD) r.vertex_index = 13'(pick_loaded());
      r.line_start_index = 13'(pick_loaded());
      if ($urandom_range(0, 3) == 0) r.line_end_index = r.vertex_index;
      if ($urandom_range(0, 1)) begin
         r.line_dx = $signed($urandom_range(0, 400)) - 200 <<< 16;
         r.line_dy = $signed($urandom_range(0, 400)) - 200 <<< 16;
      end
      return r;
   endfunction

   task automatic load_vertex(int idx, logic [31:0] x, logic [31:0] y);
      vpol_pkg::req_type r;
      r = '0; r.cmd = vpol_pkg::CMD_LOAD; r.vertex_index = 13'(idx);
      r.vertex_x = x; r.vertex_y = y;
      send_item(r);
   endtask

   task automatic proj_vertex(int idx, int ls, int le, logic [31:0] dx, logic [31:0] dy);
      vpol_pkg::req_type r;
      r = '0; r.cmd = vpol_pkg::CMD_PROJ; r.vertex_index = 13'(idx);
      r.line_start_index = 13'(ls); r.line_end_index = 13'(le);
      r.line_dx = dx; r.line_dy = dy;
      send_item(r);
   endtask

   task automatic test_directed();
      vpol_pkg::req_type r;
      load_vertex(0, 32'h8000_0000, 32'h7fff_ffff);
      load_vertex(8191, 32'h7fff_ffff, 32'h8000_0000);
      load_vertex(1, 32'h0001_0000, 32'h0003_0000);
      load_vertex(2, 32'hffff_1234, 32'h0002_8000);
      proj_vertex(1, 0, 8191, 32'h0003_0000, 32'hfffe_0000);
      proj_vertex(1, 0, 8191, 32'h0003_0000, 32'hfffe_0000);
      proj_vertex(2, 0, 8191, 0, 32'h0001_0000);
      proj_vertex(2, 0, 8191, 32'h0001_0000, 0);
      proj_vertex(0, 0, 8191, 32'h0001_0000, 32'h0001_0000);
      proj_vertex(8191, 0, 8191, 32'h0001_0000, 32'h0001_0000);
      proj_vertex(2, 1, 0, 32'h0000_8000, 32'h0000_ffff);
      proj_vertex(2, 1, 0, 32'h0000_8000, 32'h0000_ffff);
      r = '0; r.cmd = vpol_pkg::CMD_CLEAR; r.vertex_index = 13'd2; send_item(r);
      proj_vertex(2, 8191, 0, 32'h8000_0000, 32'h7fff_ffff);
      r.cmd = vpol_pkg::CMD_CLEAR; send_item(r);
      proj_vertex(1, 0, 2, 32'h7fff_ffff, 32'h8000_0000);
      proj_vertex(8191, 2, 1, 32'hffff_0000, 32'hffff_0000);
      r = '0; r.cmd = vpol_pkg::CMD_READ; r.vertex_index = 13'd8191; send_item(r);
      r.vertex_index = 13'd0; send_item(r);
   endtask

   task automatic test_random();
      int pick;
      for (int n = 0; n < 650; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35 || loaded_list.size() < 4)
            send_item(random_item(vpol_pkg::CMD_LOAD));
         else if (pick < 80)
            send_item(random_item(vpol_pkg::CMD_PROJ));
         else if (pick < 95)
            send_item(random_item(vpol_pkg::CMD_READ));
         else
            send_item(random_item(vpol_pkg::CMD_CLEAR));
      end
   endtask

   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_wait  <= 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         draw = $urandom_range(0, 9);
         rsp_wait  <= draw;
         rsp_stall <= (draw != 0);
      end else if (rsp_valid && rsp_wait > 1) begin
         rsp_wait <= rsp_wait - 1;
      end else if (rsp_valid) begin
         rsp_wait  <= 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      vpol_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $display("%0t: out_x expected %h actual %h", $time, want.out_x, rsp_data.out_x);
               errors++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $display("%0t: out_y expected %h actual %h", $time, want.out_y, rsp_data.out_y);
               errors++;
            end
            if (rsp_data.moved !== want.moved) begin
               $display("%0t: moved expected %b actual %b", $time, want.moved, rsp_data.moved);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCH_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      foreach (mark_tab[i]) mark_tab[i] = 1'b0;
      foreach (loaded[i]) loaded[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 0;
      test_directed();
      test_random();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
